FILE: src/ohfc_pkg.sv
// Package for the oven heater/fan controller: item types, codes and constants.
package ohfc_pkg;

	// Operation codes of an input item
	localparam logic [1:0] OP_CONTROL = 2'd0;
	localparam logic [1:0] OP_ENCODER = 2'd1;
	localparam logic [1:0] OP_BUTTON  = 2'd2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_EMERGENCY_LIMIT = 3'd0,
		REG_HEATER_BAND     = 3'd1,
		REG_HEATER_DWELL    = 3'd2,
		REG_FAN_DWELL       = 3'd3,
		REG_FAN_ON_DELTA    = 3'd4,
		REG_FAN_OFF_DELTA   = 3'd5,
		REG_TOP_OFFSET      = 3'd6,
		REG_BOTTOM_OFFSET   = 3'd7
	} ohfc_reg_t;

	// Temperature and setpoint limits
	localparam logic [9:0]  TEMP_CLAMP  = 10'd999;
	localparam logic [10:0] TARGET_MAX  = 11'd998;
	localparam logic [10:0] STEP_SIZE   = 11'd2;
	localparam logic [31:0] DEBOUNCE_MS = 32'd500;

	// Reset values of setpoints and configuration
	localparam logic [9:0]  ENCLOSURE_RESET   = 10'd230;
	localparam logic [9:0]  MEAT_RESET        = 10'd190;
	localparam logic [9:0]  EMERGENCY_RESET   = 10'd250;
	localparam logic [5:0]  HEATER_BAND_RESET = 6'd5;
	localparam logic [31:0] HEATER_DWELL_RESET = 32'd10000;
	localparam logic [31:0] FAN_DWELL_RESET   = 32'd60000;
	localparam logic [9:0]  FAN_ON_RESET      = 10'd30;
	localparam logic [9:0]  FAN_OFF_RESET     = 10'd15;
	localparam logic [4:0]  OFFSET_RESET      = 5'd3;

	// Input item
	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_ms;
		logic        switch_on;
		logic [10:0] top_reading;
		logic [10:0] bottom_reading;
		logic [10:0] meat_reading;
		logic        encoder_clk;
		logic        encoder_dt;
		logic        button_level;
	} ohfc_in_t;

	// Result item
	typedef struct packed {
		logic       heater_drive;
		logic       fan_drive;
		logic       error_flag;
		logic [9:0] enclosure_setpoint;
		logic [9:0] meat_setpoint;
		logic       selected_setting;
	} ohfc_out_t;

endpackage

FILE: src/oven_heater_fan_controller.sv
// Oven heater/fan controller: thermostat with hysteresis, encoder and button handling.
// An accepted item is held in the input register, then moves into the result register.
// Throughput: one item per cycle; the input register and the result register
// decouple the two channels, so a stalled result blocks input only when both are full.
// Reset (arst_n low, asynchronous): channels empty, heater and fan off, error clear,
// stamps zero, setpoints 230/190, configuration registers at their default values.
module oven_heater_fan_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  ohfc_pkg::ohfc_in_t sample,
	output logic               result_valid,
	input  logic               result_stall,
	output ohfc_pkg::ohfc_out_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ohfc_pkg::*;

	// configuration
	logic [9:0]  emergency_limit_q;
	logic [5:0]  heater_band_q;
	logic [31:0] heater_dwell_q;
	logic [31:0] fan_dwell_q;
	logic [9:0]  fan_on_delta_q;
	logic [9:0]  fan_off_delta_q;
	logic [4:0]  top_offset_q;
	logic [4:0]  bottom_offset_q;

	// controller state
	logic        heater_q, fan_q, error_q, selection_q, prev_clk_q;
	logic [31:0] heater_stamp_q, fan_stamp_q, press_stamp_q;
	logic [9:0]  enclosure_q, meat_q;

	// next state
	logic        heater_d, fan_d, error_d, selection_d, prev_clk_d;
	logic [31:0] heater_stamp_d, fan_stamp_d, press_stamp_d;
	logic [9:0]  enclosure_d, meat_d;

	// input stage
	ohfc_in_t item_s1;
	logic     valid_s1;
	logic     advance;

	// control sample datapath
	logic [11:0] top_sum, bot_sum;
	logic [9:0]  top_t, bot_t, meat_t, diff, enc_eff;
	logic        over_limit, heater_dwell_ok, fan_dwell_ok;
	logic [10:0] top_band;
	logic        encoder_rise;

	function automatic logic [9:0] move_target(input logic [9:0] t, input logic up);
		logic [10:0] sum;
		sum = {1'b0, t} + STEP_SIZE;
		if (up) begin
			move_target = (sum > TARGET_MAX) ? TARGET_MAX[9:0] : sum[9:0];
		end else begin
			move_target = ({1'b0, t} < STEP_SIZE) ? 10'd0 : t - STEP_SIZE[9:0];
		end
	endfunction

	// handshake: input register moves into result register when it is free
	assign advance      = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			item_s1 <= sample;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emergency_limit_q <= EMERGENCY_RESET;
			heater_band_q     <= HEATER_BAND_RESET;
			heater_dwell_q    <= HEATER_DWELL_RESET;
			fan_dwell_q       <= FAN_DWELL_RESET;
			fan_on_delta_q    <= FAN_ON_RESET;
			fan_off_delta_q   <= FAN_OFF_RESET;
			top_offset_q      <= OFFSET_RESET;
			bottom_offset_q   <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ohfc_reg_t'(cfg_index))
				REG_EMERGENCY_LIMIT: emergency_limit_q <= cfg_data[9:0];
				REG_HEATER_BAND:     heater_band_q     <= cfg_data[5:0];
				REG_HEATER_DWELL:    heater_dwell_q    <= cfg_data;
				REG_FAN_DWELL:       fan_dwell_q       <= cfg_data;
				REG_FAN_ON_DELTA:    fan_on_delta_q    <= cfg_data[9:0];
				REG_FAN_OFF_DELTA:   fan_off_delta_q   <= cfg_data[9:0];
				REG_TOP_OFFSET:      top_offset_q      <= cfg_data[4:0];
				REG_BOTTOM_OFFSET:   bottom_offset_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// corrected and clamped temperatures
	assign top_sum = {1'b0, item_s1.top_reading} + {7'd0, top_offset_q};
	assign bot_sum = {1'b0, item_s1.bottom_reading} + {7'd0, bottom_offset_q};
	assign top_t   = (top_sum > {2'b0, TEMP_CLAMP}) ? TEMP_CLAMP : top_sum[9:0];
	assign bot_t   = (bot_sum > {2'b0, TEMP_CLAMP}) ? TEMP_CLAMP : bot_sum[9:0];
	assign meat_t  = (item_s1.meat_reading > {1'b0, TEMP_CLAMP}) ?
			TEMP_CLAMP : item_s1.meat_reading[9:0];

	assign over_limit = (top_t >= emergency_limit_q) || (bot_t >= emergency_limit_q) ||
			(meat_t >= emergency_limit_q);

	// enclosure setpoint drops to meat setpoint once meat is done
	assign enc_eff  = (meat_t >= meat_q) ? meat_q : enclosure_q;
	assign top_band = {1'b0, top_t} + {5'd0, heater_band_q};
	assign diff     = (top_t >= bot_t) ? top_t - bot_t : bot_t - top_t;

	// dwell checks, modulo 2^32
	assign heater_dwell_ok = (item_s1.now_ms - heater_stamp_q) >= heater_dwell_q;
	assign fan_dwell_ok    = (item_s1.now_ms - fan_stamp_q) >= fan_dwell_q;

	assign encoder_rise = item_s1.encoder_clk && !prev_clk_q;

	// next state for the item in the input register
	always_comb begin
		heater_d       = heater_q;
		fan_d          = fan_q;
		error_d        = error_q;
		selection_d    = selection_q;
		prev_clk_d     = prev_clk_q;
		heater_stamp_d = heater_stamp_q;
		fan_stamp_d    = fan_stamp_q;
		press_stamp_d  = press_stamp_q;
		enclosure_d    = enclosure_q;
		meat_d         = meat_q;
		unique case (item_s1.operation)
			OP_CONTROL: begin
				error_d = (item_s1.switch_on && error_q) || over_limit;
				if (!item_s1.switch_on || error_d) begin
					heater_d = 1'b0;
					fan_d    = 1'b0;
				end else begin
					enclosure_d = enc_eff;
					// heater hysteresis
					if (!heater_q && (top_band < {1'b0, enc_eff}) && heater_dwell_ok) begin
						heater_d       = 1'b1;
						heater_stamp_d = item_s1.now_ms;
					end else if (heater_q && ((top_t >= enc_eff) || (bot_t >= enc_eff)) &&
							heater_dwell_ok) begin
						heater_d       = 1'b0;
						heater_stamp_d = item_s1.now_ms;
					end
					// fan on top-bottom difference
					if (!fan_q && (diff > fan_on_delta_q) && fan_dwell_ok) begin
						fan_d       = 1'b1;
						fan_stamp_d = item_s1.now_ms;
					end else if (fan_q && (diff <= fan_off_delta_q) && fan_dwell_ok) begin
						fan_d       = 1'b0;
						fan_stamp_d = item_s1.now_ms;
					end
				end
			end
			OP_ENCODER: begin
				if (encoder_rise) begin
					if (!selection_q) begin
						enclosure_d = move_target(enclosure_q, !item_s1.encoder_dt);
					end else begin
						meat_d = move_target(meat_q, !item_s1.encoder_dt);
					end
				end
				prev_clk_d = item_s1.encoder_clk;
			end
			OP_BUTTON: begin
				if (!item_s1.button_level &&
						((item_s1.now_ms - press_stamp_q) > DEBOUNCE_MS)) begin
					selection_d   = !selection_q;
					press_stamp_d = item_s1.now_ms;
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q       <= 1'b0;
			fan_q          <= 1'b0;
			error_q        <= 1'b0;
			selection_q    <= 1'b0;
			prev_clk_q     <= 1'b1;
			heater_stamp_q <= '0;
			fan_stamp_q    <= '0;
			press_stamp_q  <= '0;
			enclosure_q    <= ENCLOSURE_RESET;
			meat_q         <= MEAT_RESET;
		end else if (advance) begin
			heater_q       <= heater_d;
			fan_q          <= fan_d;
			error_q        <= error_d;
			selection_q    <= selection_d;
			prev_clk_q     <= prev_clk_d;
			heater_stamp_q <= heater_stamp_d;
			fan_stamp_q    <= fan_stamp_d;
			press_stamp_q  <= press_stamp_d;
			enclosure_q    <= enclosure_d;
			meat_q         <= meat_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.heater_drive       <= heater_d;
			result.fan_drive          <= fan_d;
			result.error_flag         <= error_d;
			result.enclosure_setpoint <= enclosure_d;
			result.meat_setpoint      <= meat_d;
			result.selected_setting   <= selection_d;
		end
	end

`ifndef SYNTHESIS
	// a latched error keeps heater and fan off
	assert property (@(posedge clk) disable iff (!arst_n)
		error_q |-> (!heater_q && !fan_q))
		else $error("heater or fan on while error latched");

	// setpoints stay within the target range
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, enclosure_q} <= TARGET_MAX) && ({1'b0, meat_q} <= TARGET_MAX))
		else $error("setpoint out of range");

	// a full input register behind a stalled result holds off new input
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && result_stall) |-> sample_stall)
		else $error("input not stalled while both stages are full");

	// selection changes only on a processed button item
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(selection_q) |-> $past(advance && (item_s1.operation == OP_BUTTON)))
		else $error("selection changed without a button item");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the oven heater/fan controller: scoreboard, stimulus, checks.
`timescale 1ns / 100ps

module tb_top;
	import ohfc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Thermostat scoreboard: mirrors configuration and state, queues predicted status
	class ohfc_scoreboard;
		logic [9:0]  emerg_limit;
		logic [5:0]  heat_band;
		logic [31:0] heat_dwell;
		logic [31:0] fan_dwell;
		logic [9:0]  fan_on_delta;
		logic [9:0]  fan_off_delta;
		logic [4:0]  top_ofs;
		logic [4:0]  bot_ofs;
		logic        heat_active;
		logic        fan_running;
		logic        err_latched;
		logic        sel_meat;
		logic        last_enc_clk;
		logic [31:0] heat_stamp;
		logic [31:0] fan_stamp;
		logic [31:0] press_stamp;
		logic [9:0]  encl_target;
		logic [9:0]  meat_target;
		ohfc_out_t   status_due[$];
		int          errors;

		function new();
			emerg_limit   = EMERGENCY_RESET;
			heat_band     = HEATER_BAND_RESET;
			heat_dwell    = HEATER_DWELL_RESET;
			fan_dwell     = FAN_DWELL_RESET;
			fan_on_delta  = FAN_ON_RESET;
			fan_off_delta = FAN_OFF_RESET;
			top_ofs       = OFFSET_RESET;
			bot_ofs       = OFFSET_RESET;
			heat_active   = 1'b0;
			fan_running   = 1'b0;
			err_latched   = 1'b0;
			sel_meat      = 1'b0;
			last_enc_clk  = 1'b1;
			heat_stamp    = '0;
			fan_stamp     = '0;
			press_stamp   = '0;
			encl_target   = ENCLOSURE_RESET;
			meat_target   = MEAT_RESET;
			errors        = 0;
		endfunction

		function void set_reg(ohfc_reg_t idx, logic [31:0] d);
			case (idx)
			REG_EMERGENCY_LIMIT: emerg_limit = d[9:0];
			REG_HEATER_BAND:     heat_band = d[5:0];
			REG_HEATER_DWELL:    heat_dwell = d;
			REG_FAN_DWELL:       fan_dwell = d;
			REG_FAN_ON_DELTA:    fan_on_delta = d[9:0];
			REG_FAN_OFF_DELTA:   fan_off_delta = d[9:0];
			REG_TOP_OFFSET:      top_ofs = d[4:0];
			REG_BOTTOM_OFFSET:   bot_ofs = d[4:0];
			default: ;
			endcase
		endfunction

		function logic [9:0] clamp_reading(logic [11:0] v);
			return (v > 12'd999) ? TEMP_CLAMP : v[9:0];
		endfunction

		// setpoint step by 2, held within 0..998
		function logic [9:0] nudge_target(logic [9:0] t, logic up);
			int v;
			if (up)
				v = int'(t) + int'(STEP_SIZE);
			else
				v = int'(t) - int'(STEP_SIZE);
			if (v > int'(TARGET_MAX))
				v = int'(TARGET_MAX);
			if (v < 0)
				v = 0;
			return 10'(v);
		endfunction

		// advance the controller by one item and return its status
		function ohfc_out_t thermostat_step(ohfc_in_t it);
			logic [9:0] top;
			logic [9:0] bot;
			logic [9:0] meat;
			logic [9:0] diff;
			logic       heat_ok;
			logic       fan_ok;
			ohfc_out_t  r;
			case (it.operation)
			OP_CONTROL: begin
				top  = clamp_reading({1'b0, it.top_reading} + {7'd0, top_ofs});
				bot  = clamp_reading({1'b0, it.bottom_reading} + {7'd0, bot_ofs});
				meat = clamp_reading({1'b0, it.meat_reading});
				// switch off clears the latch before the limit check
				if (!it.switch_on)
					err_latched = 1'b0;
				if (top >= emerg_limit || bot >= emerg_limit || meat >= emerg_limit)
					err_latched = 1'b1;
				if (!it.switch_on || err_latched) begin
					heat_active = 1'b0;
					fan_running = 1'b0;
				end else begin
					if (meat >= meat_target)
						encl_target = meat_target;
					heat_ok = (it.now_ms - heat_stamp) >= heat_dwell;
					fan_ok  = (it.now_ms - fan_stamp) >= fan_dwell;
					if (!heat_active && int'(top) + int'(heat_band) < int'(encl_target) &&
					    heat_ok) begin
						heat_active = 1'b1;
						heat_stamp  = it.now_ms;
					end else if (heat_active && (top >= encl_target || bot >= encl_target) &&
					             heat_ok) begin
						heat_active = 1'b0;
						heat_stamp  = it.now_ms;
					end
					diff = (top >= bot) ? top - bot : bot - top;
					if (!fan_running && diff > fan_on_delta && fan_ok) begin
						fan_running = 1'b1;
						fan_stamp   = it.now_ms;
					end else if (fan_running && diff <= fan_off_delta && fan_ok) begin
						fan_running = 1'b0;
						fan_stamp   = it.now_ms;
					end
				end
			end
			OP_ENCODER: begin
				// rising encoder clock moves the selected setpoint, dt low means up
				if (it.encoder_clk && !last_enc_clk) begin
					if (!sel_meat)
						encl_target = nudge_target(encl_target, !it.encoder_dt);
					else
						meat_target = nudge_target(meat_target, !it.encoder_dt);
				end
				last_enc_clk = it.encoder_clk;
			end
			OP_BUTTON: begin
				if (!it.button_level && (it.now_ms - press_stamp) > DEBOUNCE_MS) begin
					sel_meat    = !sel_meat;
					press_stamp = it.now_ms;
				end
			end
			default: ;
			endcase
			r.heater_drive       = heat_active;
			r.fan_drive          = fan_running;
			r.error_flag         = err_latched;
			r.enclosure_setpoint = encl_target;
			r.meat_setpoint      = meat_target;
			r.selected_setting   = sel_meat;
			return r;
		endfunction

		function void note_sample(ohfc_in_t it);
			status_due.push_back(thermostat_step(it));
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(ohfc_out_t got);
			ohfc_out_t want;
			if (status_due.size() == 0) begin
				report($sformatf("result %h with no item outstanding", got));
				return;
			end
			want = status_due.pop_front();
			if (got.heater_drive !== want.heater_drive)
				report($sformatf("heater_drive %b, want %b", got.heater_drive, want.heater_drive));
			if (got.fan_drive !== want.fan_drive)
				report($sformatf("fan_drive %b, want %b", got.fan_drive, want.fan_drive));
			if (got.error_flag !== want.error_flag)
				report($sformatf("error_flag %b, want %b", got.error_flag, want.error_flag));
			if (got.enclosure_setpoint !== want.enclosure_setpoint)
				report($sformatf("enclosure_setpoint %0d, want %0d",
				                 got.enclosure_setpoint, want.enclosure_setpoint));
			if (got.meat_setpoint !== want.meat_setpoint)
				report($sformatf("meat_setpoint %0d, want %0d",
				                 got.meat_setpoint, want.meat_setpoint));
			if (got.selected_setting !== want.selected_setting)
				report($sformatf("selected_setting %b, want %b",
				                 got.selected_setting, want.selected_setting));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	ohfc_in_t    sample;
	logic        result_valid;
	logic        result_stall;
	ohfc_out_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	ohfc_scoreboard sb;
	bit             calm;
	logic [31:0]    wall_ms;
	int             items_sent;
	int unsigned    cycles;

	oven_heater_fan_controller i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// accepted items in, accepted status out
	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall)
			sb.note_sample(sample);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// result side back-pressure, one draw per status item
	initial begin
		int hold;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	function automatic ohfc_in_t noise_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return ohfc_in_t'(raw[$bits(ohfc_in_t)-1:0]);
	endfunction

	function automatic int near(int center, int spread, int ceiling);
		int v;
		v = center - spread + $urandom_range(0, 2 * spread);
		if (v > ceiling)
			v = ceiling;
		if (v < 0)
			v = 0;
		return v;
	endfunction

	// present one item; valid stays up on return until the next call decides
	task automatic send_item(ohfc_in_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= it;
		do @(posedge clk); while (sample_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_control(logic [31:0] now, logic sw, int t, int b, int m);
		ohfc_in_t it;
		it                = noise_item();
		it.operation      = OP_CONTROL;
		it.now_ms         = now;
		it.switch_on      = sw;
		it.top_reading    = 11'(t);
		it.bottom_reading = 11'(b);
		it.meat_reading   = 11'(m);
		send_item(it);
	endtask

	task automatic send_encoder(logic pin_clk, logic pin_dt);
		ohfc_in_t it;
		it             = noise_item();
		it.operation   = OP_ENCODER;
		it.encoder_clk = pin_clk;
		it.encoder_dt  = pin_dt;
		send_item(it);
	endtask

	task automatic send_button(logic [31:0] now, logic level);
		ohfc_in_t it;
		it              = noise_item();
		it.operation    = OP_BUTTON;
		it.now_ms       = now;
		it.button_level = level;
		send_item(it);
	endtask

	// hold input until every status item is back, then let the pipeline settle
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(ohfc_reg_t idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
	endtask

	task automatic set_config(logic [31:0] lim, logic [31:0] band, logic [31:0] hdw,
	                          logic [31:0] fdw, logic [31:0] fon, logic [31:0] foff,
	                          logic [31:0] tofs, logic [31:0] bofs);
		wait_drained();
		write_reg(REG_EMERGENCY_LIMIT, lim);
		write_reg(REG_HEATER_BAND, band);
		write_reg(REG_HEATER_DWELL, hdw);
		write_reg(REG_FAN_DWELL, fdw);
		write_reg(REG_FAN_ON_DELTA, fon);
		write_reg(REG_FAN_OFF_DELTA, foff);
		write_reg(REG_TOP_OFFSET, tofs);
		write_reg(REG_BOTTOM_OFFSET, bofs);
		cfg_valid <= 1'b0;
	endtask

	// control sample with readings around the setpoints, mostly under the limit
	task automatic random_control();
		int ceil_t;
		int ceil_b;
		int t;
		int b;
		int m;
		wall_ms = wall_ms + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4000));
		ceil_t = int'(sb.emerg_limit) - int'(sb.top_ofs) - 1;
		ceil_b = int'(sb.emerg_limit) - int'(sb.bot_ofs) - 1;
		t = near(int'(sb.encl_target) - 10, 30, ceil_t);
		b = near(t, 50, ceil_b);
		m = near(int'(sb.meat_target) - 25, 30, int'(sb.emerg_limit) - 1);
		if ($urandom_range(0, 24) == 0)
			t = $urandom_range(0, 2047);
		if ($urandom_range(0, 49) == 0)
			m = $urandom_range(0, 2047);
		send_control(wall_ms, $urandom_range(0, 11) != 0, t, b, m);
	endtask

	task automatic random_traffic(int count);
		int stop;
		int pick;
		ohfc_in_t it;
		stop = items_sent + count;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				random_control();
			end else if (pick < 75) begin
				// well-formed encoder detent: low then high
				send_encoder(1'b0, $urandom_range(0, 1));
				send_encoder(1'b1, $urandom_range(0, 1));
			end else if (pick < 90) begin
				wall_ms = wall_ms + $urandom_range(0, 900);
				send_button(wall_ms, $urandom_range(0, 3) == 0);
			end else if (pick < 97) begin
				send_item(noise_item());
			end else begin
				it           = noise_item();
				it.operation = OP_UNUSED;
				send_item(it);
			end
			if ($urandom_range(0, 299) == 0)
				wait_drained();
		end
	endtask

	task automatic select_meat(logic want);
		while (sb.sel_meat !== want) begin
			wall_ms = wall_ms + 1000;
			send_button(wall_ms, 1'b0);
		end
	endtask

	// drive both setpoints into their saturation limits
	task automatic sweep_setpoints();
		select_meat(1'b0);
		while (sb.encl_target != TARGET_MAX[9:0]) begin
			send_encoder(1'b0, $urandom_range(0, 1));
			send_encoder(1'b1, 1'b0);
		end
		repeat (3) begin
			send_encoder(1'b0, $urandom_range(0, 1));
			send_encoder(1'b1, 1'b0);
		end
		calm = 1'b1;
		select_meat(1'b1);
		while (sb.meat_target != 10'd0) begin
			send_encoder(1'b0, $urandom_range(0, 1));
			send_encoder(1'b1, 1'b1);
		end
		repeat (3) begin
			send_encoder(1'b0, $urandom_range(0, 1));
			send_encoder(1'b1, 1'b1);
		end
		calm = 1'b0;
	endtask

	task automatic directed();
		ohfc_in_t it;
		it           = '1;
		it.operation = OP_UNUSED;
		send_item(it);
		send_control(32'd0, 1'b1, 0, 0, 0);
		send_control(32'd10000, 1'b1, 0, 0, 0);
		send_control(32'd10001, 1'b1, 300, 0, 0);
		send_control(32'd10002, 1'b1, 0, 0, 0);
		send_control(32'd10003, 1'b0, 0, 0, 0);
		send_control(32'd10004, 1'b0, 2047, 0, 0);
		send_control(32'd10005, 1'b0, 0, 0, 0);
		send_control(32'd20000, 1'b1, 0, 0, 200);
		send_control(32'd70000, 1'b1, 0, 60, 0);
		send_control(32'hFFFF_FFFF, 1'b1, 200, 200, 0);
		send_control(32'd1000, 1'b1, 0, 2047, 0);
		send_control(32'd1001, 1'b0, 0, 0, 0);
		send_encoder(1'b1, 1'b0);
		send_encoder(1'b0, 1'b0);
		send_encoder(1'b1, 1'b0);
		send_encoder(1'b1, 1'b1);
		send_encoder(1'b0, 1'b1);
		send_encoder(1'b1, 1'b1);
		send_button(32'd400, 1'b0);
		send_button(32'd501, 1'b0);
		send_button(32'd1001, 1'b0);
		send_button(32'd5000, 1'b1);
		send_button(32'd5000, 1'b0);
		it           = '0;
		it.operation = OP_UNUSED;
		send_item(it);
		send_control(32'd90000, 1'b1, 0, 0, 2047);
	endtask

	// main sequence
	initial begin
		sb           = new();
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		calm         = 1'b0;
		wall_ms      = 32'd100000;
		items_sent   = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed();
		random_traffic(250);
		calm = 1'b1;
		random_traffic(100);
		calm = 1'b0;

		// wide-open limits, no dwell, biggest offsets
		set_config(999, 63, 0, 0, 0, 0, 31, 31);
		random_traffic(200);

		// opposite corner: everything trips, dwell never passes
		set_config(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 999, 999, 0, 0);
		random_traffic(60);

		set_config($urandom_range(200, 999), $urandom_range(0, 63), $urandom_range(0, 20000),
		           $urandom_range(0, 90000), $urandom_range(0, 80), $urandom_range(0, 40),
		           $urandom_range(0, 31), $urandom_range(0, 31));
		random_traffic(200);

		set_config(400, 8, 500, 2000, 20, 10, 1, 2);
		sweep_setpoints();
		random_traffic(100);

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/ohfc_pkg.sv
src/oven_heater_fan_controller.sv
tb/tb_top.sv
